// ----- rtl/core/earliest_finish_worker_scheduler_macros.svh -----
// assertion macros shared by the scheduler rtl
`ifndef EARLIEST_FINISH_WORKER_SCHEDULER_MACROS_SVH
`define EARLIEST_FINISH_WORKER_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define EFWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efws check failed");

// next-cycle implication, disabled during reset
`define EFWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efws check failed");

`endif

// ----- rtl/core/efws_pkg.sv -----
// shared types, constants and saturating helpers of the worker scheduler
package efws_pkg;

    localparam int unsigned NUM_WORKERS = 4;
    localparam int unsigned WID_W       = 2;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned KIND_W      = 8;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned OBUF_DEPTH  = 2;
    localparam int unsigned OBUF_CNT_W  = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPS0        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPS1        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPS2        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAPS3        = 3'd4;

    localparam logic [CNT_W-1:0] WORKER_COUNT_RST = 3'd4;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [TIME_W-1:0] now_time;
        logic [KIND_W-1:0] task_kinds;
        logic              urgent;
        logic [TIME_W-1:0] length_w0;
        logic [TIME_W-1:0] length_w1;
        logic [TIME_W-1:0] length_w2;
        logic [TIME_W-1:0] length_w3;
        logic [NUM_WORKERS-1:0] known_mask;
        logic [WID_W-1:0]  popped_worker;
        logic [TIME_W-1:0] popped_length;
    } t_item;

    typedef struct packed {
        logic [WID_W-1:0]  chosen_worker;
        logic [TIME_W-1:0] assigned_length;
        logic              to_head;
        logic              no_eligible;
        logic [TIME_W-1:0] expected_finish;
    } t_result;

    // what one lane reports to the merge stage
    typedef struct packed {
        logic              eligible;
        logic              unknown;
        logic [TIME_W-1:0] end_time;
    } t_lane_stat;

    // what the merge stage found
    typedef struct packed {
        logic             found;
        logic             unknown;
        logic [WID_W-1:0] idx;
    } t_pick;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// ----- rtl/core/efws_lane.sv -----
// one worker lane: holds its start and queued length, computes its end time
`include "earliest_finish_worker_scheduler_macros.svh"

module efws_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  efws_pkg::t_cmd                  i_cmd,
    input  logic [efws_pkg::TIME_W-1:0]     i_now,
    input  logic                            i_enabled,
    input  logic [efws_pkg::KIND_W-1:0]     i_caps,
    input  logic [efws_pkg::KIND_W-1:0]     i_kinds,
    input  logic                            i_known,
    input  logic [efws_pkg::TIME_W-1:0]     i_pred,
    input  logic                            i_pop_sel,
    input  logic [efws_pkg::TIME_W-1:0]     i_pop_len,
    input  logic                            i_win,
    output efws_pkg::t_lane_stat            o_stat,
    output logic [efws_pkg::TIME_W-1:0]     o_fin
);

    logic [efws_pkg::TIME_W-1:0] r_start;
    logic [efws_pkg::TIME_W-1:0] r_queued;
    logic [efws_pkg::TIME_W-1:0] n_start;
    logic [efws_pkg::TIME_W-1:0] n_queued;

    logic [efws_pkg::TIME_W-1:0] w_raised;
    logic [efws_pkg::TIME_W-1:0] w_base;
    logic [efws_pkg::TIME_W-1:0] w_end;
    logic [efws_pkg::TIME_W-1:0] w_grow;
    logic [efws_pkg::TIME_W-1:0] w_pop_start;
    logic [efws_pkg::TIME_W-1:0] w_pop_queued;

    // raise start to now, then start + queued + prediction
    assign w_raised = (i_enabled && (r_start < i_now)) ? i_now : r_start;
    assign w_base   = efws_pkg::sat_add(w_raised, r_queued);
    assign w_end    = efws_pkg::sat_add(w_base, i_pred);
    assign w_grow   = efws_pkg::sat_add(r_queued, i_pred);

    // pop update values
    assign w_pop_start  = efws_pkg::sat_add(i_now, i_pop_len);
    assign w_pop_queued = efws_pkg::sat_sub(r_queued, i_pop_len);

    // status for the merge stage
    always_comb begin
        o_stat.eligible = i_enabled && ((i_caps & i_kinds) != '0);
        o_stat.unknown  = !i_known;
        o_stat.end_time = w_end;
    end

    // finish after the update, used when this lane is chosen or popped
    always_comb begin
        if (i_cmd == efws_pkg::CMD_POP) begin
            o_fin = efws_pkg::sat_add(w_pop_start, w_pop_queued);
        end else if (i_known) begin
            o_fin = w_end;
        end else begin
            o_fin = w_base;
        end
    end

    // next state
    always_comb begin
        n_start  = r_start;
        n_queued = r_queued;
        if (i_accept) begin
            if (i_cmd == efws_pkg::CMD_POP) begin
                if (i_pop_sel) begin
                    n_start  = w_pop_start;
                    n_queued = w_pop_queued;
                end
            end else begin
                n_start = w_raised;
                if (i_win && i_known) begin
                    n_queued = w_grow;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_queued <= '0;
        end else begin
            r_start  <= n_start;
            r_queued <= n_queued;
        end
    end

    // a winning lane must be able to run the task
    `EFWS_ASSERT_NOW(a_win_eligible, i_clk, i_rst_n, i_accept && i_win && (i_cmd == efws_pkg::CMD_PUSH), o_stat.eligible)

endmodule

// ----- rtl/core/efws_merge.sv -----
// merge stage: picks the first unknown lane, else the earliest end, lowest index on ties
`include "earliest_finish_worker_scheduler_macros.svh"

module efws_merge (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  efws_pkg::t_lane_stat    i_stat [efws_pkg::NUM_WORKERS],
    output efws_pkg::t_pick         o_pick
);

    typedef struct packed {
        logic                        valid;
        logic                        unknown;
        logic [efws_pkg::WID_W-1:0]  idx;
        logic [efws_pkg::TIME_W-1:0] end_time;
    } t_cand;

    // a holds the lower indexes, so it wins ties
    function automatic t_cand pick_pair(input t_cand a, input t_cand b);
        logic take_a;
        take_a = a.valid && (!b.valid || a.unknown ||
                 (!b.unknown && (a.end_time <= b.end_time)));
        return take_a ? a : b;
    endfunction

    t_cand w_leaf [efws_pkg::NUM_WORKERS];
    t_cand w_mid  [efws_pkg::NUM_WORKERS/2];
    t_cand w_root;

    // leaves from lane status
    always_comb begin
        for (int i = 0; i < efws_pkg::NUM_WORKERS; i++) begin
            w_leaf[i].valid    = i_stat[i].eligible;
            w_leaf[i].unknown  = i_stat[i].unknown;
            w_leaf[i].idx      = efws_pkg::WID_W'(i);
            w_leaf[i].end_time = i_stat[i].end_time;
        end
    end

    // two-level compare tree
    always_comb begin
        for (int i = 0; i < efws_pkg::NUM_WORKERS/2; i++) begin
            w_mid[i] = pick_pair(w_leaf[2*i], w_leaf[2*i+1]);
        end
        w_root = pick_pair(w_mid[0], w_mid[1]);
    end

    always_comb begin
        o_pick.found   = w_root.valid;
        o_pick.unknown = w_root.unknown;
        o_pick.idx     = w_root.idx;
    end

    // a pick always lands on an eligible lane
    `EFWS_ASSERT_NOW(a_pick_eligible, i_clk, i_rst_n, o_pick.found, i_stat[o_pick.idx].eligible)

endmodule

// ----- rtl/core/efws_obuf.sv -----
// two-entry result buffer between the scheduler and its consumer
`include "earliest_finish_worker_scheduler_macros.svh"

module efws_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  efws_pkg::t_result   i_data,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output efws_pkg::t_result   o_data
);

    efws_pkg::t_result             r_slot [efws_pkg::OBUF_DEPTH];
    logic                          r_wr_ptr;
    logic                          r_rd_ptr;
    logic [efws_pkg::OBUF_CNT_W-1:0] r_cnt;
    logic                          n_wr_ptr;
    logic                          n_rd_ptr;
    logic [efws_pkg::OBUF_CNT_W-1:0] n_cnt;
    logic                          w_pop;

    assign o_space = (r_cnt != efws_pkg::OBUF_CNT_W'(efws_pkg::OBUF_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    // pointer and fill count
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    `EFWS_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= efws_pkg::OBUF_CNT_W'(efws_pkg::OBUF_DEPTH))
    `EFWS_ASSERT_NOW(a_push_space, i_clk, i_rst_n, i_push, o_space)

endmodule

// ----- rtl/core/earliest_finish_worker_scheduler.sv -----
// top level of the earliest-finish worker scheduler
//
// channel   valid     ready     payload
// -------   -------   -------   ---------------------------
// item in   i_valid   o_ready   i_item   (efws_pkg::t_item)
// result    o_valid   i_ready   o_result (efws_pkg::t_result)
// config    i_cfg_we  -         i_cfg_index, i_cfg_data
//
// one item per cycle while o_ready is high: four worker lanes compute their end times side by side
// and a two-level compare tree picks the winner in the accept cycle.
// the result is in the output buffer in the cycle after the item is accepted.
// reset is synchronous; lane state clears to zero, worker_count to 4.
// the two-entry output buffer keeps input flowing while a result waits;
// o_ready falls only when both entries hold untaken results.
`include "earliest_finish_worker_scheduler_macros.svh"

module earliest_finish_worker_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [efws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [efws_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  efws_pkg::t_item                     i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output efws_pkg::t_result                   o_result
);

    logic [efws_pkg::CNT_W-1:0]  r_worker_count;
    logic [efws_pkg::KIND_W-1:0] r_caps [efws_pkg::NUM_WORKERS];

    logic                        w_accept;
    logic [efws_pkg::TIME_W-1:0] w_pred [efws_pkg::NUM_WORKERS];
    logic [efws_pkg::TIME_W-1:0] w_fin  [efws_pkg::NUM_WORKERS];
    efws_pkg::t_lane_stat        w_stat [efws_pkg::NUM_WORKERS];
    logic [efws_pkg::NUM_WORKERS-1:0] w_win;
    efws_pkg::t_pick             w_pick;
    efws_pkg::t_result           w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker_count <= efws_pkg::WORKER_COUNT_RST;
            for (int i = 0; i < efws_pkg::NUM_WORKERS; i++) begin
                r_caps[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                efws_pkg::REG_WORKER_COUNT: begin
                    r_worker_count <= i_cfg_data[efws_pkg::CNT_W-1:0];
                end
                efws_pkg::REG_CAPS0: begin
                    r_caps[0] <= i_cfg_data;
                end
                efws_pkg::REG_CAPS1: begin
                    r_caps[1] <= i_cfg_data;
                end
                efws_pkg::REG_CAPS2: begin
                    r_caps[2] <= i_cfg_data;
                end
                efws_pkg::REG_CAPS3: begin
                    r_caps[3] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_accept = i_valid && o_ready;

    // per-worker predictions
    assign w_pred[0] = i_item.length_w0;
    assign w_pred[1] = i_item.length_w1;
    assign w_pred[2] = i_item.length_w2;
    assign w_pred[3] = i_item.length_w3;

    // worker lanes
    for (genvar g = 0; g < efws_pkg::NUM_WORKERS; g++) begin : g_lane
        assign w_win[g] = w_pick.found && (w_pick.idx == efws_pkg::WID_W'(g));

        efws_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (w_accept),
            .i_cmd     (i_item.command),
            .i_now     (i_item.now_time),
            .i_enabled (r_worker_count > efws_pkg::CNT_W'(g)),
            .i_caps    (r_caps[g]),
            .i_kinds   (i_item.task_kinds),
            .i_known   (i_item.known_mask[g]),
            .i_pred    (w_pred[g]),
            .i_pop_sel (i_item.popped_worker == efws_pkg::WID_W'(g)),
            .i_pop_len (i_item.popped_length),
            .i_win     (w_win[g]),
            .o_stat    (w_stat[g]),
            .o_fin     (w_fin[g])
        );
    end

    // merge of the lane results
    efws_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_pick  (w_pick)
    );

    // result item
    always_comb begin
        w_result = '0;
        if (i_item.command == efws_pkg::CMD_POP) begin
            w_result.chosen_worker   = i_item.popped_worker;
            w_result.assigned_length = i_item.popped_length;
            w_result.expected_finish = w_fin[i_item.popped_worker];
        end else if (w_pick.found) begin
            w_result.chosen_worker   = w_pick.idx;
            w_result.assigned_length = w_pick.unknown ? '0 : w_pred[w_pick.idx];
            w_result.to_head         = i_item.urgent;
            w_result.expected_finish = w_fin[w_pick.idx];
        end else begin
            w_result.no_eligible     = 1'b1;
        end
    end

    // output buffer
    efws_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_result)
    );

    `EFWS_ASSERT_NOW(a_no_elig_zero, i_clk, i_rst_n, o_valid && o_result.no_eligible,
        (o_result.chosen_worker == '0) && (o_result.expected_finish == '0) && !o_result.to_head)
    `EFWS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, o_valid)

endmodule

// ----- tb/sv/earliest_finish_worker_scheduler_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the earliest-finish worker scheduler: mirrors its placement and compares results
module earliest_finish_worker_scheduler_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [efws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [efws_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  efws_pkg::t_item                 i_item,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  efws_pkg::t_result               o_result,
    output int                              o_fail_count,
    output int                              o_pending
);

    // shadow copy of the block's registers and per-worker timing state
    logic [efws_pkg::CNT_W-1:0]  cfg_workers;
    logic [efws_pkg::KIND_W-1:0] worker_caps    [efws_pkg::NUM_WORKERS];
    logic [efws_pkg::TIME_W-1:0] worker_start   [efws_pkg::NUM_WORKERS];
    logic [efws_pkg::TIME_W-1:0] worker_backlog [efws_pkg::NUM_WORKERS];

    efws_pkg::t_result expected_results [$];
    int                mismatch_count = 0;
    int                results_seen   = 0;
    int                outstanding    = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = outstanding;

    // one line per mismatch, and count it
    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] scheduler error at result %0d: %s", $time, results_seen, what);
    endtask

    function automatic logic [efws_pkg::TIME_W-1:0] add_clamped(
        input logic [efws_pkg::TIME_W-1:0] a,
        input logic [efws_pkg::TIME_W-1:0] b);
        logic [efws_pkg::TIME_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[efws_pkg::TIME_W] ? '1 : total[efws_pkg::TIME_W-1:0];
    endfunction

    // applies one item to the shadow state and returns the result it should produce
    function automatic efws_pkg::t_result predict_schedule(input efws_pkg::t_item it);
        efws_pkg::t_result           r;
        logic [efws_pkg::TIME_W-1:0] offers [efws_pkg::NUM_WORKERS];
        logic [efws_pkg::TIME_W-1:0] finish_at;
        logic [efws_pkg::TIME_W-1:0] best_end;
        logic [efws_pkg::TIME_W-1:0] best_len;
        logic [efws_pkg::WID_W-1:0]  best;
        logic                        found;
        logic                        took_unknown;
        int                          live;
        r         = '0;
        offers[0] = it.length_w0;
        offers[1] = it.length_w1;
        offers[2] = it.length_w2;
        offers[3] = it.length_w3;
        live      = (cfg_workers > efws_pkg::NUM_WORKERS) ? efws_pkg::NUM_WORKERS :
                    int'(cfg_workers);

        // pop: release work from one worker, enabled or not
        if (it.command == efws_pkg::CMD_POP) begin
            best = it.popped_worker;
            worker_backlog[best] = (worker_backlog[best] > it.popped_length) ?
                                   worker_backlog[best] - it.popped_length : '0;
            worker_start[best]   = add_clamped(it.now_time, it.popped_length);
            r.chosen_worker      = best;
            r.assigned_length    = it.popped_length;
            r.expected_finish    = add_clamped(worker_start[best], worker_backlog[best]);
            return r;
        end

        // enabled workers cannot start before now
        for (int i = 0; i < live; i++) begin
            if (worker_start[i] < it.now_time) worker_start[i] = it.now_time;
        end

        // first capable worker with no prediction wins outright, else earliest end
        found        = 1'b0;
        took_unknown = 1'b0;
        best         = '0;
        best_len     = '0;
        best_end     = '0;
        for (int i = 0; i < live; i++) begin
            if (!took_unknown && (worker_caps[i] & it.task_kinds) != '0) begin
                if (!it.known_mask[i]) begin
                    found        = 1'b1;
                    took_unknown = 1'b1;
                    best         = efws_pkg::WID_W'(i);
                    best_len     = '0;
                end else begin
                    finish_at = add_clamped(add_clamped(worker_start[i], worker_backlog[i]),
                                            offers[i]);
                    if (!found || finish_at < best_end) begin
                        found    = 1'b1;
                        best     = efws_pkg::WID_W'(i);
                        best_len = offers[i];
                        best_end = finish_at;
                    end
                end
            end
        end

        if (!found) begin
            r.no_eligible = 1'b1;
            return r;
        end

        worker_backlog[best] = add_clamped(worker_backlog[best], best_len);
        r.chosen_worker      = best;
        r.assigned_length    = best_len;
        r.to_head            = it.urgent;
        r.expected_finish    = add_clamped(worker_start[best], worker_backlog[best]);
        return r;
    endfunction

    // field-by-field compare against the oldest prediction
    task automatic compare_result(input efws_pkg::t_result got);
        efws_pkg::t_result want;
        results_seen++;
        if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("item with nothing expected (worker %0d finish %0d)",
                                    got.chosen_worker, got.expected_finish));
            return;
        end
        want = expected_results.pop_front();
        if (got.chosen_worker !== want.chosen_worker)
            flag_mismatch($sformatf("chosen_worker got %0d want %0d",
                                    got.chosen_worker, want.chosen_worker));
        if (got.assigned_length !== want.assigned_length)
            flag_mismatch($sformatf("assigned_length got %0d want %0d",
                                    got.assigned_length, want.assigned_length));
        if (got.to_head !== want.to_head)
            flag_mismatch($sformatf("to_head got %0b want %0b", got.to_head, want.to_head));
        if (got.no_eligible !== want.no_eligible)
            flag_mismatch($sformatf("no_eligible got %0b want %0b",
                                    got.no_eligible, want.no_eligible));
        if (got.expected_finish !== want.expected_finish)
            flag_mismatch($sformatf("expected_finish got %0d want %0d",
                                    got.expected_finish, want.expected_finish));
    endtask

    // watch register writes and both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_workers = efws_pkg::WORKER_COUNT_RST;
            for (int i = 0; i < efws_pkg::NUM_WORKERS; i++) begin
                worker_caps[i]    = '0;
                worker_start[i]   = '0;
                worker_backlog[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    efws_pkg::REG_WORKER_COUNT: cfg_workers = i_cfg_data[efws_pkg::CNT_W-1:0];
                    efws_pkg::REG_CAPS0:        worker_caps[0] = i_cfg_data;
                    efws_pkg::REG_CAPS1:        worker_caps[1] = i_cfg_data;
                    efws_pkg::REG_CAPS2:        worker_caps[2] = i_cfg_data;
                    efws_pkg::REG_CAPS3:        worker_caps[3] = i_cfg_data;
                    default:                    ;
                endcase
            end
            if (o_valid && i_ready) compare_result(o_result);
            if (i_valid && o_ready) expected_results.push_back(predict_schedule(i_item));
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- tb/sv/earliest_finish_worker_scheduler_tb.sv -----
`timescale 1ns / 100ps
// stimulus and verdict for the earliest-finish worker scheduler
module earliest_finish_worker_scheduler_tb;

    typedef struct {
        logic [efws_pkg::WID_W-1:0]  worker;
        logic [efws_pkg::TIME_W-1:0] length;
    } t_queued_task;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 105;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [efws_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [efws_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            i_valid     = 1'b0;
    logic                            o_ready;
    efws_pkg::t_item                 i_item      = '0;
    logic                            o_valid;
    logic                            i_ready     = 1'b0;
    efws_pkg::t_result               o_result;

    int fail_count;
    int pending_count;

    // stimulus bookkeeping
    bit                          idle_on = 1'b1;
    logic [efws_pkg::TIME_W-1:0] clock_us = '0;
    efws_pkg::t_cmd              sent_cmds [$];
    t_queued_task                open_tasks [$];
    int                          items_sent       = 0;
    int                          pushes_sent      = 0;
    int                          pops_sent        = 0;
    int                          settings_applied = 0;
    int                          no_eligible_seen = 0;

    earliest_finish_worker_scheduler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

    earliest_finish_worker_scheduler_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (i_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("timed out waiting on the scheduler");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one register write per cycle; caller drops the write enable
    task automatic write_reg(input logic [efws_pkg::CFG_IDX_W-1:0] idx,
                             input logic [efws_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [efws_pkg::CNT_W-1:0] count,
                                input logic [efws_pkg::KIND_W-1:0] c0,
                                input logic [efws_pkg::KIND_W-1:0] c1,
                                input logic [efws_pkg::KIND_W-1:0] c2,
                                input logic [efws_pkg::KIND_W-1:0] c3);
        write_reg(efws_pkg::REG_WORKER_COUNT, efws_pkg::CFG_DATA_W'(count));
        write_reg(efws_pkg::REG_CAPS0, c0);
        write_reg(efws_pkg::REG_CAPS1, c1);
        write_reg(efws_pkg::REG_CAPS2, c2);
        write_reg(efws_pkg::REG_CAPS3, c3);
        // stray write above the last register, must change nothing
        write_reg(efws_pkg::REG_CAPS3 + efws_pkg::CFG_IDX_W'($urandom_range(1, 3)),
                  efws_pkg::CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // drop valid, then let every outstanding result drain
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // optional gap, then hold the item until it is taken
    task automatic send_item(input efws_pkg::t_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        sent_cmds.push_back(it.command);
        items_sent++;
        if (it.command == efws_pkg::CMD_PUSH) pushes_sent++;
        else pops_sent++;
        @(negedge i_clk);
    endtask

    function automatic efws_pkg::t_item push_item(
        input logic [efws_pkg::TIME_W-1:0] now,
        input logic [efws_pkg::KIND_W-1:0] kinds, input logic urgent,
        input logic [efws_pkg::TIME_W-1:0] l0, input logic [efws_pkg::TIME_W-1:0] l1,
        input logic [efws_pkg::TIME_W-1:0] l2, input logic [efws_pkg::TIME_W-1:0] l3,
        input logic [efws_pkg::NUM_WORKERS-1:0] known);
        efws_pkg::t_item it;
        it            = '0;
        it.command    = efws_pkg::CMD_PUSH;
        it.now_time   = now;
        it.task_kinds = kinds;
        it.urgent     = urgent;
        it.length_w0  = l0;
        it.length_w1  = l1;
        it.length_w2  = l2;
        it.length_w3  = l3;
        it.known_mask = known;
        return it;
    endfunction

    function automatic efws_pkg::t_item pop_item(input logic [efws_pkg::TIME_W-1:0] now,
                                                 input logic [efws_pkg::WID_W-1:0] worker,
                                                 input logic [efws_pkg::TIME_W-1:0] length);
        efws_pkg::t_item it;
        it               = '0;
        it.command       = efws_pkg::CMD_POP;
        it.now_time      = now;
        it.popped_worker = worker;
        it.popped_length = length;
        return it;
    endfunction

    // mostly short lengths so placements compete, with extremes mixed in
    function automatic logic [efws_pkg::TIME_W-1:0] rand_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return efws_pkg::TIME_MAX;
            2:       return efws_pkg::TIME_W'($urandom);
            default: return efws_pkg::TIME_W'($urandom_range(1, 2000));
        endcase
    endfunction

    // kind masks for tasks and worker capabilities
    function automatic logic [efws_pkg::KIND_W-1:0] rand_kinds();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return efws_pkg::KIND_W'(1) << $urandom_range(0, efws_pkg::KIND_W - 1);
            default: return efws_pkg::KIND_W'($urandom);
        endcase
    endfunction

    // time mostly creeps forward; rarely slips back or jumps
    function automatic logic [efws_pkg::TIME_W-1:0] advance_clock();
        case ($urandom_range(0, 49))
            0:       clock_us = clock_us - efws_pkg::TIME_W'($urandom_range(0, 500));
            1:       clock_us = efws_pkg::TIME_W'($urandom);
            default: clock_us = (clock_us > efws_pkg::TIME_MAX - efws_pkg::TIME_W'(300)) ?
                                efws_pkg::TIME_MAX :
                                clock_us + efws_pkg::TIME_W'($urandom_range(0, 300));
        endcase
        return clock_us;
    endfunction

    // push or pop with random content; pops mostly release a task that was placed
    function automatic efws_pkg::t_item random_item();
        efws_pkg::t_item it;
        int              pick;
        it.command       = efws_pkg::CMD_PUSH;
        it.now_time      = advance_clock();
        it.task_kinds    = rand_kinds();
        it.urgent        = 1'($urandom_range(0, 1));
        it.length_w0     = rand_length();
        it.length_w1     = rand_length();
        it.length_w2     = rand_length();
        it.length_w3     = rand_length();
        it.known_mask    = $urandom_range(0, 1) ? '1 :
                           efws_pkg::NUM_WORKERS'($urandom_range(0, 15));
        it.popped_worker = efws_pkg::WID_W'($urandom_range(0, efws_pkg::NUM_WORKERS - 1));
        it.popped_length = rand_length();
        if ($urandom_range(0, 9) >= 6) begin
            it.command = efws_pkg::CMD_POP;
            if (open_tasks.size() > 0 && $urandom_range(0, 4) != 0) begin
                pick             = $urandom_range(0, open_tasks.size() - 1);
                it.popped_worker = open_tasks[pick].worker;
                it.popped_length = open_tasks[pick].length;
                open_tasks.delete(pick);
            end
        end
        return it;
    endfunction

    // result side: random stall per item, remembers placements for later pops
    initial begin : result_sink
        int             stall;
        efws_pkg::t_cmd cmd;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (sent_cmds.size() > 0) begin
                cmd = sent_cmds.pop_front();
                if (cmd == efws_pkg::CMD_PUSH && o_result.no_eligible) no_eligible_seen++;
                else if (cmd == efws_pkg::CMD_PUSH)
                    open_tasks.push_back('{o_result.chosen_worker, o_result.assigned_length});
            end
            @(negedge i_clk);
        end
    end

    // main sequence
    initial begin
        efws_pkg::t_item             all_ones;
        logic [efws_pkg::CNT_W-1:0]  count;
        logic [efws_pkg::KIND_W-1:0] caps [efws_pkg::NUM_WORKERS];

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: mixed capabilities over all four workers
        apply_config(efws_pkg::CNT_W'(4), 8'h01, 8'h03, 8'h02, 8'hFF);
        // cheapest known worker
        send_item(push_item(32'd0, 8'h01, 1'b0, 32'd100, 32'd200, 32'd300, 32'd400, 4'hF));
        // capable worker without a prediction is taken with length zero
        send_item(push_item(32'd0, 8'h02, 1'b1, 32'd50, 32'd60, 32'd70, 32'd80, 4'b1101));
        // only worker 3 can run it, end time saturates
        send_item(push_item(32'd10, 8'h80, 1'b0, efws_pkg::TIME_MAX, efws_pkg::TIME_MAX,
                            efws_pkg::TIME_MAX, efws_pkg::TIME_MAX, 4'hF));
        // equal lengths, tie goes to the lowest index
        send_item(push_item(32'd20, 8'hFF, 1'b1, 32'd500, 32'd500, 32'd500, 32'd500, 4'hF));
        // no worker handles an empty kind mask
        send_item(push_item(32'd30, 8'h00, 1'b1, 32'd1, 32'd1, 32'd1, 32'd1, 4'hF));
        // saturating pop, then a pop larger than the queued work
        send_item(pop_item(32'd40, 2'd3, efws_pkg::TIME_MAX));
        send_item(pop_item(32'd50, 2'd0, 32'd5000));
        send_item(push_item(efws_pkg::TIME_MAX, 8'hFF, 1'b1, efws_pkg::TIME_MAX,
                            efws_pkg::TIME_MAX, efws_pkg::TIME_MAX, efws_pkg::TIME_MAX, 4'hF));
        // time going backwards on a pop and on a push
        send_item(pop_item(32'd5, 2'd2, 32'd7));
        send_item(push_item(32'd3, 8'h03, 1'b0, 32'd1, 32'd2, 32'd3, 32'd4, 4'h0));
        wait_idle();

        // zero workers: pushes find nobody, pops still land
        apply_config(efws_pkg::CNT_W'(0), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(push_item(32'd60, 8'hFF, 1'b1, 32'd9, 32'd9, 32'd9, 32'd9, 4'hF));
        send_item(pop_item(32'd70, 2'd1, 32'd20));
        wait_idle();

        // count above the worker range enables all of them
        apply_config('1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(push_item(32'd100, 8'hFF, 1'b0, 32'd1, 32'd1, 32'd1, 32'd1, 4'hE));
        all_ones = '1;
        send_item(all_ones);
        all_ones.command = efws_pkg::CMD_PUSH;
        send_item(all_ones);
        wait_idle();

        // single worker with no capability; pop of a disabled worker
        apply_config(efws_pkg::CNT_W'(1), 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_item(push_item(32'd200, 8'hFF, 1'b0, 32'd5, 32'd5, 32'd5, 32'd5, 4'hF));
        send_item(pop_item(32'd210, 2'd3, 32'd15));
        wait_idle();

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       count = efws_pkg::CNT_W'(4);
                1:       count = efws_pkg::CNT_W'(1);
                2:       count = '1;
                3:       count = '0;
                4:       count = efws_pkg::CNT_W'(2);
                5:       count = efws_pkg::CNT_W'(3);
                default: count = efws_pkg::CNT_W'($urandom_range(0, 7));
            endcase
            for (int i = 0; i < efws_pkg::NUM_WORKERS; i++) caps[i] = (p == 0) ? '1 : rand_kinds();
            if (p == 6) clock_us = 32'hFFFF_F000;
            else if (p % 3 == 1) clock_us = efws_pkg::TIME_W'($urandom);
            else clock_us = efws_pkg::TIME_W'($urandom_range(0, 1000));
            idle_on = !(p == 2 || p == 5);
            apply_config(count, caps[0], caps[1], caps[2], caps[3]);
            repeat (PHASE_ITEMS) send_item(random_item());
            wait_idle();
        end

        $display("covered %0d items (%0d pushes, %0d pops) over %0d register settings",
                 items_sent, pushes_sent, pops_sent, settings_applied);
        $display("%0d placements found no eligible worker", no_eligible_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
